>>> hdl/sbe_pkg.sv
`timescale 1ns / 1ps
// Package with the shared types, constants and coding function of the sub-frame encoder.
package sbe_pkg;

    localparam int BLOCK_FRAMES = 192;
    localparam int SUBFRAMES    = 2 * BLOCK_FRAMES;
    localparam int POS_W        = $clog2(SUBFRAMES);

    localparam logic [31:0] PRE_B = 32'h3317_3333;
    localparam logic [31:0] PRE_M = 32'h331d_3333;
    localparam logic [31:0] PRE_W = 32'h331b_3333;

    localparam logic [15:0] GAIN_RESET = 16'h8000;
    localparam int          GAIN_SHIFT = 15;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic               restart;
    } t_in_word;

    typedef struct packed {
        logic [31:0] preamble_word;
        logic [30:0] data_word;
        logic        right_channel;
        logic        block_start;
    } t_out_word;

    typedef struct packed {
        logic [15:0] scaled;
        logic        restart;
    } t_queue_word;

    typedef struct packed {
        logic        valid;
        t_queue_word word;
    } t_queue_xfer;

    // Biphase-mark code of one byte; the first half-cell is high.
    function automatic logic [15:0] bmc_byte(input logic [7:0] b);
        logic [15:0] code;
        logic        level;
        logic        first;
        code  = '0;
        level = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            first              = level ^ b[i];
            code[(7 - i) * 2]     = level;
            code[(7 - i) * 2 + 1] = first;
            level              = ~first;
        end
        return code;
    endfunction

endpackage

>>> hdl/sbe_in_if.sv
`timescale 1ns / 1ps
// Interface for the input sample channel.
interface sbe_in_if;
    logic              valid;
    logic              ready;
    sbe_pkg::t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/sbe_out_if.sv
`timescale 1ns / 1ps
// Interface for the output sub-frame channel.
interface sbe_out_if;
    logic               valid;
    logic               ready;
    sbe_pkg::t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/sbe_front.sv
`timescale 1ns / 1ps
// Front end: gain register, sample accept and unsigned Q1.15 volume scaling.
module sbe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_queue_full,
    sbe_in_if.sink               i_in,
    output sbe_pkg::t_queue_xfer o_push
);

    logic [15:0]        r_gain;
    logic signed [32:0] w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= sbe_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    assign w_prod = 33'(i_in.payload.sample_value) * 33'($signed({1'b0, r_gain}));

    assign i_in.ready           = ~i_queue_full;
    assign o_push.valid         = i_in.valid & ~i_queue_full;
    assign o_push.word.scaled   = w_prod[sbe_pkg::GAIN_SHIFT + 15:sbe_pkg::GAIN_SHIFT];
    assign o_push.word.restart  = i_in.payload.restart;

endmodule

>>> hdl/sbe_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the encoder back end.
module sbe_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbe_pkg::t_queue_xfer i_push,
    input  logic                 i_pop,
    output logic                 o_full,
    output sbe_pkg::t_queue_xfer o_head
);

    sbe_pkg::t_queue_word r_mem [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count;
    logic                 w_do_pop;

    assign w_do_pop = i_pop & (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push.valid} - {1'b0, w_do_pop};
        end
    end

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.word  = r_mem[r_rd_ptr];

endmodule

>>> hdl/sbe_back.sv
`timescale 1ns / 1ps
// Back end: sub-frame position, preamble choice, biphase coding and output register.
module sbe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbe_pkg::t_queue_xfer i_head,
    output logic                 o_pop,
    sbe_out_if.source            o_out
);

    logic [sbe_pkg::POS_W-1:0] r_pos;
    logic [sbe_pkg::POS_W-1:0] w_pos;
    logic [sbe_pkg::POS_W-1:0] n_pos;
    logic                      r_out_valid;
    sbe_pkg::t_out_word        r_out;
    sbe_pkg::t_out_word        n_out;
    logic [15:0]               w_lo_code;
    logic [15:0]               w_hi_code;

    assign o_pop = i_head.valid & (~r_out_valid | o_out.ready);

    assign w_pos = i_head.word.restart ? '0 : r_pos;
    assign n_pos = (w_pos >= sbe_pkg::POS_W'(sbe_pkg::SUBFRAMES - 1)) ? '0
                 : w_pos + sbe_pkg::POS_W'(1);

    assign w_lo_code = sbe_pkg::bmc_byte(i_head.word.scaled[7:0]);
    assign w_hi_code = sbe_pkg::bmc_byte(i_head.word.scaled[15:8]);

    always_comb begin
        n_out.block_start   = (w_pos == '0);
        n_out.right_channel = w_pos[0];
        if (w_pos == '0) begin
            n_out.preamble_word = sbe_pkg::PRE_B;
        end else if (w_pos[0]) begin
            n_out.preamble_word = sbe_pkg::PRE_W;
        end else begin
            n_out.preamble_word = sbe_pkg::PRE_M;
        end
        n_out.data_word = {w_lo_code[14:0] ^ {15{w_hi_code[15]}}, w_hi_code};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos       <= n_pos;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

>>> hdl/spdif_subframe_bmc_encoder.sv
`timescale 1ns / 1ps
// Top level of the S/PDIF sub-frame biphase-mark encoder.
//
//   Channel   Direction  Word
//   i_in      sink       signed PCM sample and restart flag
//   o_out     source     preamble word, data word, channel and block start
//   cfg       write      unsigned Q1.15 volume gain
//
// One word is taken per cycle while the queue is not full; a result passes through the queue and the output register.
// The gain multiply sits in the front end and is registered in a two-entry queue.
// The back end codes the word and holds it in an output register while o_out stalls.
// With o_out stalled, the queue and the output register hold three words before i_in stalls.
// Reset sets the gain to unity and the sub-frame position to the start of a block.
module spdif_subframe_bmc_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    sbe_in_if.sink      i_in,
    sbe_out_if.source   o_out
);

    sbe_pkg::t_queue_xfer w_push;
    sbe_pkg::t_queue_xfer w_head;
    logic                 w_full;
    logic                 w_pop;

    sbe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_queue_full (w_full),
        .i_in         (i_in),
        .o_push       (w_push)
    );

    sbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    sbe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
